/* rtl/bst_pkg.sv */
// Shared types and constants for the bencode stream tokenizer.
`default_nettype none

package bst_pkg;

    // Bytes of the bencode grammar
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'

    // Magnitudes are 63 bits: limit is 2^63-1
    localparam int MAG_W = 63;
    localparam logic [MAG_W-1:0] MAG_LIMIT_DIV10 = 63'd922337203685477580;
    localparam logic [3:0] MAG_LIMIT_LAST = 4'd7;

    // Parser mode
    typedef enum logic [3:0] {
        MODE_VALUE,
        MODE_INT_START,
        MODE_INT_NEG,
        MODE_INT_DIGITS,
        MODE_INT_ZERO,
        MODE_STR_NEG,
        MODE_STR_DIGITS,
        MODE_STR_ZERO,
        MODE_STR_BODY,
        MODE_DONE,
        MODE_ERROR
    } mode_t;

    // Kind of an open container on the stack
    typedef enum logic [1:0] {
        CONT_NONE = 2'd0,
        CONT_LIST = 2'd1,
        CONT_DKEY = 2'd2,
        CONT_DVAL = 2'd3
    } cont_t;

    // Token kinds on the result channel
    typedef enum logic [2:0] {
        TOK_INT    = 3'd0,
        TOK_HDR    = 3'd1,
        TOK_BYTE   = 3'd2,
        TOK_LIST   = 3'd3,
        TOK_DICT   = 3'd4,
        TOK_END    = 3'd5,
        TOK_ERROR  = 3'd6
    } tok_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_SYNTAX   = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_END_OPEN = 2'd2,
        ERR_TOO_DEEP = 2'd3
    } err_t;

    // What the current byte produces
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ERROR,
        ACT_INT,
        ACT_HDR,
        ACT_BYTE,
        ACT_OPEN,
        ACT_CLOSE
    } act_t;

    // Stack command from the parser
    typedef struct packed {
        logic  clear;
        logic  push;
        logic  pop;
        logic  flip;     // dict key/value toggle on the (new) top
        cont_t kind;     // kind pushed
    } stk_cmd_t;

    // Result token payload (nest level travels separately, its width varies)
    typedef struct packed {
        tok_t        kind;
        logic [63:0] value;
        logic [7:0]  content;
        logic        key;
        logic        done;
        err_t        err;
    } res_t;

    // Dict entry toggles between awaiting key and awaiting value
    function automatic cont_t flip_kind(input cont_t k);
        cont_t r;
        case (k)
            CONT_DKEY: r = CONT_DVAL;
            CONT_DVAL: r = CONT_DKEY;
            default:   r = k;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/bst_stack.sv */
// Container stack with the top entry and the one below held in registers.
`default_nettype none

module bst_stack
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH = 16,
    localparam int LEVEL_W = $clog2(MAX_DEPTH + 1),
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cmd_valid,
    input  stk_cmd_t           cmd,
    output logic [LEVEL_W-1:0] level,
    output cont_t              top_kind
);

    logic [LEVEL_W-1:0] level_reg, level_next;
    cont_t              top_reg, top_next;
    cont_t              below_reg;
    cont_t              base_kind;
    cont_t              mem [MAX_DEPTH];
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [LEVEL_W-1:0] rd_level;
    logic               do_push;

    assign do_push = cmd_valid && cmd.push;

    // Next level and next top entry
    always_comb begin
        level_next = level_reg;
        top_next   = top_reg;
        base_kind  = (cmd.pop) ? below_reg : top_reg;
        if (cmd_valid) begin
            if (cmd.clear) begin
                level_next = '0;
            end else if (cmd.push) begin
                level_next = level_reg + LEVEL_W'(1);
                top_next   = cmd.kind;
            end else begin
                if (cmd.pop) begin
                    level_next = level_reg - LEVEL_W'(1);
                end
                top_next = (cmd.flip) ? flip_kind(base_kind) : base_kind;
            end
        end
    end

    // Old top spills to level-1; next "below" sits at level_next-2
    assign wr_addr  = IDX_W'(level_reg - LEVEL_W'(1));
    assign rd_level = level_next - LEVEL_W'(2);
    assign rd_addr  = IDX_W'(rd_level);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
    end

    // Spill memory and registered read of the entry below the top
    always_ff @(posedge aclk) begin
        if (do_push && level_reg != '0) begin
            mem[wr_addr] <= top_reg;
        end
        if (do_push) begin
            below_reg <= top_reg;
        end else if (level_next >= LEVEL_W'(2)) begin
            below_reg <= mem[rd_addr];
        end
    end

    assign level    = level_reg;
    assign top_kind = (level_reg == '0) ? CONT_NONE : top_reg;

endmodule

`default_nettype wire

/* rtl/bencode_stream_tokenizer.sv */
// Top level: bencode syntax checker and tokenizer, one byte per transaction.
// A byte accepted into the input register yields its token (if any) from the result register.
// Throughput: one byte per cycle while the token channel does not stall; the input
// register and result register form a two-stage pipe.
// Reset (aresetn low, synchronous): parser expects a new document at top level,
// both channels empty. Stack contents are not cleared; only pushed entries are read.
`default_nettype none

module bencode_stream_tokenizer
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH = 16,
    localparam int LEVEL_W = $clog2(MAX_DEPTH + 1),
    localparam int M_BITS = 64 + 8 + LEVEL_W + 4,
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // input byte stream
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,   // [7:0] stream_byte
    input  wire                 s_tlast,   // end_of_input
    // token stream
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // number_value, content_byte, nest_level,
                                           // is_dict_key, document_complete,
                                           // error_code, zero pad (low bit up)
    output logic [2:0]          m_tuser    // token_kind
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic       proceed;

    // Parser state
    mode_t            mode_reg, mode_next;
    logic [MAG_W-1:0] acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] rem_reg, rem_next;

    // Stack
    stk_cmd_t           cmd;
    logic [LEVEL_W-1:0] level;
    cont_t              top_kind;

    // Decode
    logic             is_digit;
    logic [3:0]       digit;
    logic             acc_ovf;
    logic [MAG_W-1:0] acc_step;
    act_t             act;
    err_t             err;
    logic             done;
    logic             key;

    // Result register
    logic               m_valid_reg;
    res_t               res_reg, res_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;

    assign proceed  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proceed;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    // Byte classes and decimal accumulate (acc*10 + d as shift-adds)
    assign is_digit = in_byte_reg inside {[CH_0:CH_9]};
    assign digit    = 4'(in_byte_reg - CH_0);
    assign acc_ovf  = (acc_reg > MAG_LIMIT_DIV10) ||
                      ((acc_reg == MAG_LIMIT_DIV10) && (digit > MAG_LIMIT_LAST));
    assign acc_step = {acc_reg[MAG_W-4:0], 3'b000} + {acc_reg[MAG_W-2:0], 1'b0}
                      + MAG_W'(digit);
    assign key      = (top_kind == CONT_DKEY);

    // Next-state logic
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        cmd       = '0;
        cmd.kind  = CONT_LIST;
        act       = ACT_NONE;
        err       = ERR_SYNTAX;
        done      = 1'b0;

        if (in_eoi_reg) begin
            if (mode_reg != MODE_DONE && mode_reg != MODE_ERROR) begin
                act = ACT_ERROR;
                err = (level != '0) ? ERR_END_OPEN : ERR_SYNTAX;
            end
            mode_next = MODE_VALUE;
            acc_next  = '0;
            neg_next  = 1'b0;
            rem_next  = '0;
            cmd.clear = 1'b1;
        end else begin
            case (mode_reg)
                MODE_VALUE: begin
                    if (in_byte_reg == CH_E &&
                        (top_kind == CONT_LIST || top_kind == CONT_DKEY)) begin
                        act     = ACT_CLOSE;
                        cmd.pop = 1'b1;
                        if (level == LEVEL_W'(1)) begin
                            done      = 1'b1;
                            mode_next = MODE_DONE;
                        end else begin
                            cmd.flip = 1'b1;
                        end
                    end else if (top_kind == CONT_DKEY) begin
                        // key must be a string
                        if (in_byte_reg == CH_MINUS) begin
                            mode_next = MODE_STR_NEG;
                            acc_next  = '0;
                            neg_next  = 1'b1;
                        end else if (in_byte_reg == CH_0) begin
                            mode_next = MODE_STR_ZERO;
                            acc_next  = '0;
                            neg_next  = 1'b0;
                        end else if (is_digit) begin
                            mode_next = MODE_STR_DIGITS;
                            acc_next  = MAG_W'(digit);
                            neg_next  = 1'b0;
                        end else begin
                            act = ACT_ERROR;
                        end
                    end else if (in_byte_reg == CH_I) begin
                        mode_next = MODE_INT_START;
                        acc_next  = '0;
                        neg_next  = 1'b0;
                    end else if (in_byte_reg == CH_L || in_byte_reg == CH_D) begin
                        if (level >= LEVEL_W'(MAX_DEPTH)) begin
                            act = ACT_ERROR;
                            err = ERR_TOO_DEEP;
                        end else begin
                            act      = ACT_OPEN;
                            cmd.push = 1'b1;
                            cmd.kind = (in_byte_reg == CH_L) ? CONT_LIST : CONT_DKEY;
                        end
                    end else if (in_byte_reg == CH_0) begin
                        mode_next = MODE_STR_ZERO;
                        acc_next  = '0;
                        neg_next  = 1'b0;
                    end else if (is_digit) begin
                        mode_next = MODE_STR_DIGITS;
                        acc_next  = MAG_W'(digit);
                        neg_next  = 1'b0;
                    end else begin
                        act = ACT_ERROR;
                    end
                end
                MODE_INT_START: begin
                    if (in_byte_reg == CH_0) begin
                        mode_next = MODE_INT_ZERO;
                    end else if (in_byte_reg == CH_MINUS) begin
                        mode_next = MODE_INT_NEG;
                        acc_next  = '0;
                        neg_next  = 1'b1;
                    end else if (is_digit) begin
                        mode_next = MODE_INT_DIGITS;
                        acc_next  = MAG_W'(digit);
                        neg_next  = 1'b0;
                    end else begin
                        act = ACT_ERROR;
                    end
                end
                MODE_INT_NEG, MODE_STR_NEG: begin
                    if (is_digit) begin
                        acc_next  = MAG_W'(digit);
                        mode_next = (mode_reg == MODE_INT_NEG) ? MODE_INT_DIGITS
                                                               : MODE_STR_DIGITS;
                    end else begin
                        act = ACT_ERROR;
                    end
                end
                MODE_INT_DIGITS, MODE_INT_ZERO: begin
                    if (mode_reg == MODE_INT_DIGITS && is_digit) begin
                        if (acc_ovf) begin
                            act = ACT_ERROR;
                            err = ERR_OVERFLOW;
                        end else begin
                            acc_next = acc_step;
                        end
                    end else if (in_byte_reg == CH_E) begin
                        act      = ACT_INT;
                        acc_next = '0;
                        neg_next = 1'b0;
                        if (level == '0) begin
                            done      = 1'b1;
                            mode_next = MODE_DONE;
                        end else begin
                            cmd.flip  = 1'b1;
                            mode_next = MODE_VALUE;
                        end
                    end else begin
                        act = ACT_ERROR;
                    end
                end
                MODE_STR_DIGITS, MODE_STR_ZERO: begin
                    if (mode_reg == MODE_STR_DIGITS && is_digit) begin
                        if (acc_ovf) begin
                            act = ACT_ERROR;
                            err = ERR_OVERFLOW;
                        end else begin
                            acc_next = acc_step;
                        end
                    end else if (in_byte_reg == CH_COLON) begin
                        if (neg_reg && acc_reg != '0) begin
                            act = ACT_ERROR;
                        end else begin
                            act      = ACT_HDR;
                            acc_next = '0;
                            neg_next = 1'b0;
                            if (acc_reg != '0) begin
                                rem_next  = acc_reg;
                                mode_next = MODE_STR_BODY;
                            end else if (level == '0) begin
                                done      = 1'b1;
                                mode_next = MODE_DONE;
                            end else begin
                                cmd.flip  = 1'b1;
                                mode_next = MODE_VALUE;
                            end
                        end
                    end else begin
                        act = ACT_ERROR;
                    end
                end
                MODE_STR_BODY: begin
                    act      = ACT_BYTE;
                    rem_next = rem_reg - MAG_W'(1);
                    if (rem_reg == MAG_W'(1)) begin
                        if (level == '0) begin
                            done      = 1'b1;
                            mode_next = MODE_DONE;
                        end else begin
                            cmd.flip  = 1'b1;
                            mode_next = MODE_VALUE;
                        end
                    end
                end
                MODE_DONE, MODE_ERROR: begin
                    // bytes ignored until end of input
                end
                default: begin
                    act = ACT_ERROR;
                end
            endcase
            if (act == ACT_ERROR) begin
                mode_next = MODE_ERROR;
            end
        end
    end

    // Result payload
    always_comb begin
        res_next      = '0;
        res_next.done = done;
        lvl_next      = level;
        case (act)
            ACT_ERROR: begin
                res_next.kind = TOK_ERROR;
                res_next.err  = err;
            end
            ACT_INT: begin
                res_next.kind  = TOK_INT;
                res_next.value = neg_reg ? (64'd0 - {1'b0, acc_reg}) : {1'b0, acc_reg};
            end
            ACT_HDR: begin
                res_next.kind  = TOK_HDR;
                res_next.value = {1'b0, acc_reg};
                res_next.key   = key;
            end
            ACT_BYTE: begin
                res_next.kind    = TOK_BYTE;
                res_next.content = in_byte_reg;
                res_next.key     = key;
            end
            ACT_OPEN: begin
                res_next.kind = (in_byte_reg == CH_L) ? TOK_LIST : TOK_DICT;
            end
            ACT_CLOSE: begin
                res_next.kind = TOK_END;
                lvl_next      = level - LEVEL_W'(1);
            end
            default: begin
                res_next.kind = TOK_INT;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_VALUE;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            rem_reg  <= '0;
        end else if (proceed) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            rem_reg  <= rem_next;
        end
    end

    bst_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (proceed),
        .cmd       (cmd),
        .level     (level),
        .top_kind  (top_kind)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proceed) begin
            m_valid_reg <= (act != ACT_NONE);
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && act != ACT_NONE) begin
            res_reg <= res_next;
            lvl_reg <= lvl_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = M_DATA_W'({res_reg.err, res_reg.done, res_reg.key, lvl_reg,
                                 res_reg.content, res_reg.value});

endmodule

`default_nettype wire

/* bench/tb_bencode_stream_tokenizer.sv */
// Self-checking testbench for the bencode stream tokenizer: directed table, then random documents.
`default_nettype none

module tb_bencode_stream_tokenizer
    import bst_pkg::*;
();

    localparam int DEPTH_LIMIT  = 16;
    localparam int LEVEL_W      = $clog2(DEPTH_LIMIT + 1);
    localparam int DATA_W       = ((64 + 8 + LEVEL_W + 4 + 7) / 8) * 8;
    localparam int LEVEL_LSB    = 72;
    localparam int KEY_BIT      = LEVEL_LSB + LEVEL_W;
    localparam int DONE_BIT     = KEY_BIT + 1;
    localparam int ERR_LSB      = KEY_BIT + 2;
    localparam int RANDOM_ITEMS = 1900;
    localparam int GEN_NEST     = 4;

    typedef struct {
        tok_t               kind;
        logic [63:0]        value;
        logic [7:0]         content;
        logic [LEVEL_W-1:0] level;
        logic               key;
        logic               done;
        err_t               err;
    } token_t;

    // One row of the directed table; pinned rows carry a hand-written token
    typedef struct {
        logic [7:0] b;
        logic       eoi;
        bit         pinned;
        token_t     tok;
    } step_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [7:0]        s_tdata = 8'h00;   // [7:0] stream_byte
    logic              s_tlast = 1'b0;    // end_of_input
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire  [DATA_W-1:0] m_tdata;           // number_value, content_byte, nest_level,
                                          // is_dict_key, document_complete,
                                          // error_code, zero pad (low bit up)
    wire  [2:0]        m_tuser;           // token_kind

    bencode_stream_tokenizer #(.MAX_DEPTH(DEPTH_LIMIT)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Tokens still owed by the block, oldest first
    token_t token_q[$];
    int     mismatches = 0;
    int     live_items = 0;
    int     cyc = 0;

    // Parser state mirrored by the predictor
    mode_t       pmode;
    logic [63:0] acc;
    logic        neg;
    logic [63:0] remaining;
    cont_t       cstack[DEPTH_LIMIT];
    int          lvl;
    bit          finished;
    bit          latched;
    bit          tok_ready;
    token_t      tok_out;

    // Random document under construction
    logic [7:0] doc_bytes[$];
    int         gen_left[GEN_NEST];
    bit         gen_dict[GEN_NEST];
    bit         gen_want_val[GEN_NEST];
    int         gen_depth;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Random idling, off during one long quiet window
    function automatic bit idle_now();
        return (cyc < 800 || cyc >= 1600) && ($urandom_range(0, 99) < 8);
    endfunction

    function automatic token_t make_tok(tok_t k, logic [63:0] v, logic [7:0] c, int level,
                                        logic key, logic done, err_t e);
        token_t t;
        t.kind    = k;
        t.value   = v;
        t.content = c;
        t.level   = LEVEL_W'(level);
        t.key     = key;
        t.done    = done;
        t.err     = e;
        return t;
    endfunction

    // ---------------- predictor ----------------

    function automatic void reset_parser();
        pmode     = MODE_VALUE;
        acc       = '0;
        neg       = 1'b0;
        remaining = '0;
        lvl       = 0;
        finished  = 1'b0;
        latched   = 1'b0;
        foreach (cstack[i]) cstack[i] = CONT_NONE;
    endfunction

    function automatic void emit(tok_t k, logic [63:0] v, logic [7:0] c, logic key,
                                 logic done, err_t e);
        tok_ready = 1'b1;
        tok_out   = make_tok(k, v, c, lvl, key, done, e);
    endfunction

    function automatic void fail_parse(err_t e);
        latched = 1'b1;
        pmode   = MODE_ERROR;
        emit(TOK_ERROR, '0, '0, 1'b0, 1'b0, e);
    endfunction

    function automatic void begin_number(mode_t m, logic [63:0] a, logic n);
        pmode = m;
        acc   = a;
        neg   = n;
    endfunction

    // A value ended: finish the document at top level, else flip the dict slot
    function automatic bit close_value();
        if (lvl == 0) begin
            finished = 1'b1;
            pmode    = MODE_DONE;
            return 1'b1;
        end
        if (cstack[lvl-1] == CONT_DKEY)
            cstack[lvl-1] = CONT_DVAL;
        else if (cstack[lvl-1] == CONT_DVAL)
            cstack[lvl-1] = CONT_DKEY;
        pmode = MODE_VALUE;
        return 1'b0;
    endfunction

    // Adds a digit; true when the magnitude would pass 2^63-1
    function automatic bit grow(logic [3:0] d);
        if (acc > 64'(MAG_LIMIT_DIV10) ||
            (acc == 64'(MAG_LIMIT_DIV10) && d > MAG_LIMIT_LAST))
            return 1'b1;
        acc = acc * 10 + 64'(d);
        return 1'b0;
    endfunction

    function automatic void string_header(cont_t top);
        logic        key;
        logic [63:0] len;
        bit          done;
        key = (top == CONT_DKEY);
        len = acc;
        if (neg && len != 0) begin
            fail_parse(ERR_SYNTAX);
            return;
        end
        acc = '0;
        neg = 1'b0;
        if (len == 0) begin
            done = close_value();
            emit(TOK_HDR, '0, '0, key, done, ERR_SYNTAX);
        end else begin
            remaining = len;
            pmode     = MODE_STR_BODY;
            emit(TOK_HDR, len, '0, key, 1'b0, ERR_SYNTAX);
        end
    endfunction

    // One accepted transaction: updates state, sets tok_ready/tok_out
    function automatic void tokenize_byte(logic [7:0] c, logic eoi);
        cont_t       top;
        bit          dig;
        logic [3:0]  d;
        logic [63:0] v;
        bit          done;
        tok_ready = 1'b0;
        top = (lvl > 0) ? cstack[lvl-1] : CONT_NONE;
        dig = (c >= CH_0) && (c <= CH_9);
        d   = 4'(c - CH_0);
        if (eoi) begin
            if (!latched && !finished)
                fail_parse((lvl > 0) ? ERR_END_OPEN : ERR_SYNTAX);
            reset_parser();
            return;
        end
        if (latched || finished)
            return;
        case (pmode)
            MODE_VALUE: begin
                if (c == CH_E && (top == CONT_LIST || top == CONT_DKEY)) begin
                    lvl--;
                    done = close_value();
                    emit(TOK_END, '0, '0, 1'b0, done, ERR_SYNTAX);
                end else if (top == CONT_DKEY) begin
                    if (c == CH_MINUS) begin_number(MODE_STR_NEG, '0, 1'b1);
                    else if (c == CH_0) begin_number(MODE_STR_ZERO, '0, 1'b0);
                    else if (dig) begin_number(MODE_STR_DIGITS, 64'(d), 1'b0);
                    else fail_parse(ERR_SYNTAX);
                end else if (c == CH_I) begin
                    begin_number(MODE_INT_START, '0, 1'b0);
                end else if (c == CH_L || c == CH_D) begin
                    if (lvl >= DEPTH_LIMIT) begin
                        fail_parse(ERR_TOO_DEEP);
                    end else begin
                        emit((c == CH_L) ? TOK_LIST : TOK_DICT, '0, '0, 1'b0, 1'b0, ERR_SYNTAX);
                        cstack[lvl] = (c == CH_L) ? CONT_LIST : CONT_DKEY;
                        lvl++;
                    end
                end else if (c == CH_0) begin
                    begin_number(MODE_STR_ZERO, '0, 1'b0);
                end else if (dig) begin
                    begin_number(MODE_STR_DIGITS, 64'(d), 1'b0);
                end else begin
                    fail_parse(ERR_SYNTAX);
                end
            end
            MODE_INT_START: begin
                if (c == CH_0) pmode = MODE_INT_ZERO;
                else if (c == CH_MINUS) begin_number(MODE_INT_NEG, '0, 1'b1);
                else if (dig) begin_number(MODE_INT_DIGITS, 64'(d), 1'b0);
                else fail_parse(ERR_SYNTAX);
            end
            MODE_INT_NEG, MODE_STR_NEG: begin
                if (!dig) begin
                    fail_parse(ERR_SYNTAX);
                end else begin
                    acc   = 64'(d);
                    pmode = (pmode == MODE_INT_NEG) ? MODE_INT_DIGITS : MODE_STR_DIGITS;
                end
            end
            MODE_INT_DIGITS, MODE_INT_ZERO: begin
                if (pmode == MODE_INT_DIGITS && dig) begin
                    if (grow(d)) fail_parse(ERR_OVERFLOW);
                end else if (c == CH_E) begin
                    v    = neg ? (64'd0 - acc) : acc;
                    acc  = '0;
                    neg  = 1'b0;
                    done = close_value();
                    emit(TOK_INT, v, '0, 1'b0, done, ERR_SYNTAX);
                end else begin
                    fail_parse(ERR_SYNTAX);
                end
            end
            MODE_STR_DIGITS, MODE_STR_ZERO: begin
                if (pmode == MODE_STR_DIGITS && dig) begin
                    if (grow(d)) fail_parse(ERR_OVERFLOW);
                end else if (c == CH_COLON) begin
                    string_header(top);
                end else begin
                    fail_parse(ERR_SYNTAX);
                end
            end
            MODE_STR_BODY: begin
                remaining--;
                done = 1'b0;
                if (remaining == 0)
                    done = close_value();
                emit(TOK_BYTE, '0, c, top == CONT_DKEY, done, ERR_SYNTAX);
            end
            default: fail_parse(ERR_SYNTAX);
        endcase
    endfunction

    // ---------------- document generator ----------------

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endfunction

    // Mostly grammar bytes, some anything
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 17))
            0: return CH_I;
            1: return CH_L;
            2: return CH_D;
            3: return CH_E;
            4: return CH_COLON;
            5: return CH_MINUS;
            6: return CH_0;
            7: return CH_9;
            8: return "5";
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_int();
        logic [62:0] mag;
        string       s;
        int          small_val;
        case ($urandom_range(0, 19))
            0: s = "0";
            1: s = "-0";
            2: s = "9223372036854775807";
            3: s = "-9223372036854775807";
            4: s = "9223372036854775808";
            5: s = "-9223372036854775808";
            6: s = "123456789012345678901234";
            7: s = $sformatf("0%0d", $urandom_range(0, 99));
            8: s = "-";
            9, 10, 11: begin
                mag = 63'({$urandom, $urandom});
                mag = mag >> $urandom_range(0, 62);
                if ($urandom_range(0, 1)) s = $sformatf("-%0d", mag);
                else s = $sformatf("%0d", mag);
            end
            default: begin
                small_val = $urandom_range(0, 1998);
                s = $sformatf("%0d", small_val - 999);
            end
        endcase
        push_text({"i", s, "e"});
    endfunction

    function automatic void add_str();
        int    n;
        int    r;
        string h;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 24);
        r = $urandom_range(0, 29);
        if (r == 0) begin
            h = "-0";
            n = 0;
        end else if (r == 1) begin
            n = $urandom_range(1, 9);
            h = $sformatf("-%0d", n);
        end else if (r == 2) begin
            h = $sformatf("0%0d", n);
        end else begin
            h = $sformatf("%0d", n);
        end
        push_text({h, ":"});
        repeat (n) doc_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_value();
        if (gen_depth < GEN_NEST && $urandom_range(0, 2) == 0) begin
            gen_dict[gen_depth]     = 1'($urandom_range(0, 1));
            gen_left[gen_depth]     = $urandom_range(0, 3);
            gen_want_val[gen_depth] = 1'b0;
            doc_bytes.push_back(gen_dict[gen_depth] ? CH_D : CH_L);
            gen_depth++;
        end else if ($urandom_range(0, 1)) begin
            add_int();
        end else begin
            add_str();
        end
    endfunction

    // Random document, not always well-formed, or a run of nested lists
    function automatic void build_doc();
        int n;
        doc_bytes.delete();
        gen_depth = 0;
        if ($urandom_range(0, 24) == 0) begin
            n = $urandom_range(13, 18);
            repeat (n) doc_bytes.push_back(CH_L);
            push_text("i7e");
            repeat (n) doc_bytes.push_back(CH_E);
            return;
        end
        add_value();
        while (gen_depth > 0) begin
            if (gen_left[gen_depth-1] == 0) begin
                doc_bytes.push_back(CH_E);
                gen_depth--;
            end else if (gen_dict[gen_depth-1] && !gen_want_val[gen_depth-1]) begin
                add_str();
                gen_want_val[gen_depth-1] = 1'b1;
            end else begin
                gen_left[gen_depth-1]--;
                gen_want_val[gen_depth-1] = 1'b0;
                add_value();
            end
        end
    endfunction

    // Break some documents: trailing junk, a bad byte, a cut, or pure noise
    function automatic void mangle_doc();
        int r;
        int sz;
        int k;
        r  = $urandom_range(0, 99);
        sz = doc_bytes.size();
        if (r < 70) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) doc_bytes.push_back(noise_byte());
        end else if (r < 80 && sz > 0) begin
            doc_bytes[$urandom_range(0, sz - 1)] = noise_byte();
        end else if (r < 90 && sz > 1) begin
            k = $urandom_range(0, sz - 1);
            while (doc_bytes.size() > k) void'(doc_bytes.pop_back());
        end else begin
            doc_bytes.delete();
            repeat ($urandom_range(1, 8)) doc_bytes.push_back(noise_byte());
        end
    endfunction

    // ---------------- input side ----------------

    task automatic send_item(input logic [7:0] b, input logic eoi, input bit pinned,
                             input token_t ptok);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // transaction accepted at this edge
        live_items++;
        tokenize_byte(b, eoi);
        if (pinned) token_q.push_back(ptok);
        else if (tok_ready) token_q.push_back(tok_out);
    endtask

    // ---------------- result side ----------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_token();
        token_t want;
        if (token_q.size() == 0) begin
            report_mismatch($sformatf("unexpected token kind %0d", m_tuser));
            return;
        end
        want = token_q.pop_front();
        if (m_tuser != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
        if (m_tdata[63:0] != want.value)
            report_mismatch($sformatf("value %0d, want %0d",
                                      $signed(m_tdata[63:0]), $signed(want.value)));
        if (m_tdata[71:64] != want.content)
            report_mismatch($sformatf("content %02h, want %02h", m_tdata[71:64], want.content));
        if (m_tdata[KEY_BIT-1:LEVEL_LSB] != want.level)
            report_mismatch($sformatf("level %0d, want %0d",
                                      m_tdata[KEY_BIT-1:LEVEL_LSB], want.level));
        if (m_tdata[KEY_BIT] != want.key)
            report_mismatch($sformatf("dict key %0b, want %0b", m_tdata[KEY_BIT], want.key));
        if (m_tdata[DONE_BIT] != want.done)
            report_mismatch($sformatf("complete %0b, want %0b", m_tdata[DONE_BIT], want.done));
        if (m_tdata[ERR_LSB+1:ERR_LSB] != want.err)
            report_mismatch($sformatf("error code %0d, want %0d",
                                      m_tdata[ERR_LSB+1:ERR_LSB], want.err));
    endtask

    // Sink: check each accepted transaction, stall at random
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_token();
            m_tready <= !idle_now();
        end
    end

    // ---------------- stimulus ----------------

    function automatic step_t plain(logic [7:0] b, logic eoi);
        step_t s;
        s.b      = b;
        s.eoi    = eoi;
        s.pinned = 1'b0;
        s.tok    = make_tok(TOK_INT, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX);
        return s;
    endfunction

    function automatic step_t pin(logic [7:0] b, logic eoi, tok_t k, logic [63:0] v,
                                  logic [7:0] c, int level, logic key, logic done, err_t e);
        step_t s;
        s.b      = b;
        s.eoi    = eoi;
        s.pinned = 1'b1;
        s.tok    = make_tok(k, v, c, level, key, done, e);
        return s;
    endfunction

    initial begin
        step_t  steps[$];
        token_t blank;
        int     w;

        reset_parser();
        blank = make_tok(TOK_INT, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX);

        // "i0e": shortest integer finishes the document
        steps.push_back(plain(CH_I, 1'b0));
        steps.push_back(plain(CH_0, 1'b0));
        steps.push_back(pin(CH_E, 1'b0, TOK_INT, '0, '0, 0, 1'b0, 1'b1, ERR_SYNTAX));
        steps.push_back(plain(8'h00, 1'b1));
        // empty dict
        steps.push_back(pin(CH_D, 1'b0, TOK_DICT, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(pin(CH_E, 1'b0, TOK_END, '0, '0, 0, 1'b0, 1'b1, ERR_SYNTAX));
        steps.push_back(plain(8'hFF, 1'b1));
        // bad byte inside a list, then bytes ignored until end of input
        steps.push_back(pin(CH_L, 1'b0, TOK_LIST, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(pin("x", 1'b0, TOK_ERROR, '0, '0, 1, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(plain(8'h00, 1'b1));
        // one-byte string with an all-ones content byte
        steps.push_back(plain("1", 1'b0));
        steps.push_back(pin(CH_COLON, 1'b0, TOK_HDR, 64'd1, '0, 0, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(pin(8'hFF, 1'b0, TOK_BYTE, '0, 8'hFF, 0, 1'b0, 1'b1, ERR_SYNTAX));
        steps.push_back(plain(8'h00, 1'b1));
        // end of input before any value
        steps.push_back(pin(8'h00, 1'b1, TOK_ERROR, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX));
        // end of input inside a container
        steps.push_back(pin(CH_L, 1'b0, TOK_LIST, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(pin(8'h00, 1'b1, TOK_ERROR, '0, '0, 1, 1'b0, 1'b0, ERR_END_OPEN));
        // negative key length
        steps.push_back(plain(CH_D, 1'b0));
        steps.push_back(plain(CH_MINUS, 1'b0));
        steps.push_back(plain("1", 1'b0));
        steps.push_back(pin(CH_COLON, 1'b0, TOK_ERROR, '0, '0, 1, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(plain(8'h00, 1'b1));
        // empty key, then 'e' where the value belongs
        steps.push_back(pin(CH_D, 1'b0, TOK_DICT, '0, '0, 0, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(plain(CH_0, 1'b0));
        steps.push_back(pin(CH_COLON, 1'b0, TOK_HDR, '0, '0, 1, 1'b1, 1'b0, ERR_SYNTAX));
        steps.push_back(pin(CH_E, 1'b0, TOK_ERROR, '0, '0, 1, 1'b0, 1'b0, ERR_SYNTAX));
        steps.push_back(plain(8'h00, 1'b1));

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (steps[i])
            send_item(steps[i].b, steps[i].eoi, steps[i].pinned, steps[i].tok);

        // random documents, each closed by end of input
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            build_doc();
            mangle_doc();
            foreach (doc_bytes[i])
                send_item(doc_bytes[i], 1'b0, 1'b0, blank);
            send_item(8'($urandom), 1'b1, 1'b0, blank);
        end
        s_tvalid <= 1'b0;

        // drain
        for (w = 0; w < 20000 && token_q.size() != 0; w++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (token_q.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", token_q.size()));
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
